[rtl/core/wmf_pkg.sv]
// Shared constants, types and functions of the window median filter.
package wmf_pkg;

  localparam int WIN_H       = 3;
  localparam int WIN_W       = 3;
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int WIN_N       = WIN_H * WIN_W;
  localparam int MID_HI      = WIN_N / 2;
  localparam int MID_LO      = (WIN_N > 1) ? (WIN_N / 2 - 1) : 0;

  localparam int PIX_W       = 8;
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 13;
  localparam int CTR_W       = 3;
  localparam int ROW_W       = 12;
  localparam int COL_W       = 11;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W      = (WIN_H > 1) ? $clog2(WIN_H) : 1;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_CENTER_COL   = 2'd2,
    CFG_CENTER_ROW   = 2'd3
  } cfg_reg_e;

  typedef logic [PIX_W-1:0]              pix_t;
  typedef logic [WIN_H-1:0][PIX_W-1:0]   col_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0]   win_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } tag_t;

  typedef struct packed {
    col_t col;
    logic emit;
    tag_t tag;
  } col_item_t;

  // one round of odd-even transposition sort; phase picks the pairing
  function automatic win_t oe_step(input win_t w, input logic phase);
    win_t r;
    r = w;
    for (int i = 0; i + 1 < WIN_N; i++) begin
      if ((i[0] == phase) && (w[i] > w[i+1])) begin
        r[i]   = w[i+1];
        r[i+1] = w[i];
      end
    end
    return r;
  endfunction

  function automatic pix_t win_median(input win_t s);
    logic [PIX_W:0] sum;
    sum = {1'b0, s[MID_LO]} + {1'b0, s[MID_HI]};
    if ((WIN_N % 2) == 1) begin
      return s[MID_HI];
    end
    return sum[PIX_W:1];
  endfunction

endpackage

[rtl/core/wmf_ifs.sv]
// Stream interfaces of the window median filter.
interface wmf_pix_if;
  logic                      valid;
  logic                      ready;
  logic [wmf_pkg::PIX_W-1:0] pixel;
  logic                      frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface wmf_res_if;
  logic                      valid;
  logic                      ready;
  logic [wmf_pkg::PIX_W-1:0] median;
  logic [wmf_pkg::ROW_W-1:0] out_row;
  logic [wmf_pkg::COL_W-1:0] out_col;
  logic                      frame_last;
  modport source (output valid, median, out_row, out_col, frame_last, input ready);
  modport sink (input valid, median, out_row, out_col, frame_last, output ready);
endinterface

interface wmf_col_if;
  logic               valid;
  logic               ready;
  wmf_pkg::col_item_t item;
  modport source (output valid, item, input ready);
  modport sink (input valid, item, output ready);
endinterface

[rtl/core/wmf_front.sv]
// Front end: configuration, raster counters, line buffers and window classification.
module wmf_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data,
  wmf_pix_if.sink                        pix,
  wmf_col_if.source                      col
);

  logic [wmf_pkg::WIDTH_W-1:0]  image_width;
  logic [wmf_pkg::HEIGHT_W-1:0] image_height;
  logic [wmf_pkg::CTR_W-1:0]    center_col;
  logic [wmf_pkg::CTR_W-1:0]    center_row;

  logic [wmf_pkg::WIDTH_W-1:0]  col_count;
  logic [wmf_pkg::ROW_W-1:0]    row_count;
  logic [wmf_pkg::SLOT_W-1:0]   slot_count;

  logic [wmf_pkg::WIDTH_W-1:0]  w_eff;
  logic [wmf_pkg::HEIGHT_W-1:0] h_eff;
  logic [wmf_pkg::CTR_W-1:0]    cc;
  logic [wmf_pkg::CTR_W-1:0]    cr;
  logic [wmf_pkg::WIDTH_W-1:0]  c;
  logic [wmf_pkg::ROW_W-1:0]    r;
  logic [wmf_pkg::SLOT_W-1:0]   s;
  logic                         in_range;
  logic                         emit;
  logic                         col_wrap;
  logic                         row_wrap;
  logic [wmf_pkg::ROW_W-1:0]    row_tag;
  logic [wmf_pkg::WIDTH_W-1:0]  col_tag;
  logic                         last;
  logic [wmf_pkg::ADDR_W-1:0]   addr;
  logic                         accept;

  logic                         s1_valid;
  wmf_pkg::pix_t                s1_pixel;
  logic [wmf_pkg::SLOT_W-1:0]   s1_slot;
  logic                         s1_emit;
  wmf_pkg::tag_t                s1_tag;
  wmf_pkg::pix_t                rd_col [wmf_pkg::WIN_H];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= wmf_pkg::WIDTH_W'(640);
      image_height <= wmf_pkg::HEIGHT_W'(480);
      center_col   <= wmf_pkg::CTR_W'(1);
      center_row   <= wmf_pkg::CTR_W'(1);
    end else if (cfg_we) begin
      unique case (wmf_pkg::cfg_reg_e'(cfg_index))
        wmf_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[wmf_pkg::WIDTH_W-1:0];
        wmf_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[wmf_pkg::HEIGHT_W-1:0];
        wmf_pkg::CFG_CENTER_COL:   center_col   <= cfg_data[wmf_pkg::CTR_W-1:0];
        wmf_pkg::CFG_CENTER_ROW:   center_row   <= cfg_data[wmf_pkg::CTR_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = wmf_pkg::WIDTH_W'(1);
    end else if (int'(image_width) > wmf_pkg::MAX_WIDTH) begin
      w_eff = wmf_pkg::WIDTH_W'(wmf_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = wmf_pkg::HEIGHT_W'(1);
    end else if (int'(image_height) > wmf_pkg::MAX_HEIGHT) begin
      h_eff = wmf_pkg::HEIGHT_W'(wmf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    cc = (int'(center_col) > wmf_pkg::WIN_W - 1) ? wmf_pkg::CTR_W'(wmf_pkg::WIN_W - 1)
                                                 : center_col;
    cr = (int'(center_row) > wmf_pkg::WIN_H - 1) ? wmf_pkg::CTR_W'(wmf_pkg::WIN_H - 1)
                                                 : center_row;

    c = pix.frame_start ? '0 : col_count;
    r = pix.frame_start ? '0 : row_count;
    s = pix.frame_start ? '0 : slot_count;

    in_range = int'(c) < wmf_pkg::MAX_WIDTH;
    addr     = wmf_pkg::ADDR_W'(c);
    emit     = (c < w_eff) && ({1'b0, r} < h_eff)
            && (int'(r) >= wmf_pkg::WIN_H - 1) && (int'(c) >= wmf_pkg::WIN_W - 1);
    row_tag  = r - wmf_pkg::ROW_W'(wmf_pkg::WIN_H - 1) + wmf_pkg::ROW_W'(cr);
    col_tag  = c - wmf_pkg::WIDTH_W'(wmf_pkg::WIN_W - 1) + wmf_pkg::WIDTH_W'(cc);
    last     = ({1'b0, r} == h_eff - 1'b1) && (c == w_eff - 1'b1);
    col_wrap = ({1'b0, c} + 1'b1) >= {1'b0, w_eff};
    row_wrap = ({1'b0, r} + 1'b1) >= h_eff;
  end

  assign pix.ready = !s1_valid || col.ready;
  assign accept    = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      slot_count <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_count <= '0;
        if (row_wrap) begin
          row_count  <= '0;
          slot_count <= '0;
        end else begin
          row_count  <= r + 1'b1;
          slot_count <= (int'(s) == wmf_pkg::WIN_H - 1) ? '0 : s + 1'b1;
        end
      end else begin
        col_count  <= c + 1'b1;
        row_count  <= r;
        slot_count <= s;
      end
    end
  end

  // one line memory per window row; each read at the current column
  for (genvar g = 0; g < wmf_pkg::WIN_H; g++) begin : gen_line
    wmf_pkg::pix_t line_mem [wmf_pkg::MAX_WIDTH];
    wmf_pkg::pix_t rd_q;

    always_ff @(posedge clk) begin
      if (accept && in_range && (s == wmf_pkg::SLOT_W'(g))) begin
        line_mem[addr] <= pix.pixel;
      end
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        rd_q <= line_mem[addr];
      end
    end

    assign rd_col[g] = rd_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (col.ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel    <= pix.pixel;
      s1_slot     <= s;
      s1_emit     <= emit;
      s1_tag.row  <= row_tag;
      s1_tag.col  <= col_tag[wmf_pkg::COL_W-1:0];
      s1_tag.last <= last;
    end
  end

  // the row being written this transfer comes from the pixel itself
  always_comb begin
    for (int g = 0; g < wmf_pkg::WIN_H; g++) begin
      col.item.col[g] = (s1_slot == wmf_pkg::SLOT_W'(g)) ? s1_pixel : rd_col[g];
    end
    col.item.emit = s1_emit;
    col.item.tag  = s1_tag;
  end

  assign col.valid = s1_valid;

endmodule

[rtl/core/wmf_queue.sv]
// Short FIFO of window columns between front and back end.
module wmf_queue (
  input  logic       clk,
  input  logic       rst,
  wmf_col_if.sink    push,
  wmf_col_if.source  pop
);

  wmf_pkg::col_item_t           entries [wmf_pkg::QUEUE_DEPTH];
  logic [wmf_pkg::QPTR_W-1:0]   wr_ptr;
  logic [wmf_pkg::QPTR_W-1:0]   rd_ptr;
  logic [wmf_pkg::QPTR_W:0]     count;
  logic                         do_push;
  logic                         do_pop;

  assign push.ready = count != (wmf_pkg::QPTR_W + 1)'(wmf_pkg::QUEUE_DEPTH);
  assign pop.valid  = count != '0;
  assign pop.item   = entries[rd_ptr];
  assign do_push    = push.valid && push.ready;
  assign do_pop     = pop.valid && pop.ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/wmf_back.sv]
// Back end: window shift register, pipelined sorting network and result register.
module wmf_back (
  input  logic       clk,
  input  logic       rst,
  wmf_col_if.sink    col,
  wmf_res_if.source  res
);

  wmf_pkg::col_t   win_cols [wmf_pkg::WIN_W];
  wmf_pkg::win_t   next_win;
  wmf_pkg::win_t   st_data  [wmf_pkg::WIN_N+1];
  wmf_pkg::tag_t   st_tag   [wmf_pkg::WIN_N+1];
  logic            st_valid [wmf_pkg::WIN_N+1];

  logic            adv;
  logic            pop;
  logic            out_valid;
  wmf_pkg::pix_t   out_median;
  wmf_pkg::tag_t   out_tag;

  assign adv       = !out_valid || res.ready;
  assign col.ready = adv;
  assign pop       = col.valid && adv;

  always_comb begin
    for (int i = 0; i < wmf_pkg::WIN_W - 1; i++) begin
      for (int j = 0; j < wmf_pkg::WIN_H; j++) begin
        next_win[i*wmf_pkg::WIN_H + j] = win_cols[i+1][j];
      end
    end
    for (int j = 0; j < wmf_pkg::WIN_H; j++) begin
      next_win[(wmf_pkg::WIN_W-1)*wmf_pkg::WIN_H + j] = col.item.col[j];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < wmf_pkg::WIN_W - 1; i++) begin
        win_cols[i] <= win_cols[i+1];
      end
      win_cols[wmf_pkg::WIN_W-1] <= col.item.col;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_data[0] <= next_win;
      st_tag[0]  <= col.item.tag;
      for (int k = 1; k <= wmf_pkg::WIN_N; k++) begin
        st_data[k] <= wmf_pkg::oe_step(st_data[k-1], 1'(k-1));
        st_tag[k]  <= st_tag[k-1];
      end
      out_median <= wmf_pkg::win_median(st_data[wmf_pkg::WIN_N]);
      out_tag    <= st_tag[wmf_pkg::WIN_N];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= wmf_pkg::WIN_N; k++) begin
        st_valid[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      st_valid[0] <= pop && col.item.emit;
      for (int k = 1; k <= wmf_pkg::WIN_N; k++) begin
        st_valid[k] <= st_valid[k-1];
      end
      out_valid <= st_valid[wmf_pkg::WIN_N];
    end
  end

  assign res.valid      = out_valid;
  assign res.median     = out_median;
  assign res.out_row    = out_tag.row;
  assign res.out_col    = out_tag.col;
  assign res.frame_last = out_tag.last;

endmodule

[rtl/core/window_median_filter.sv]
// Streaming 3x3 median filter over 8-bit grey pixels in raster order.
// Takes one pixel per clock when the result side keeps up; each line memory has one
// write and one read port and is touched once per pixel, which sets that rate.
// A result passes the front register, queue, window register, nine sorting rounds and
// result register after its pixel. A four-entry queue between the front end and the
// sorting pipeline lets pixels keep arriving while a result waits, until the queue
// is full. Windows that reach past the image edge give no result, and nothing clears
// the line memories after reset.
module window_median_filter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data,
  wmf_pix_if.sink                        pix,
  wmf_res_if.source                      res
);

  wmf_col_if front_q ();
  wmf_col_if q_back ();

  wmf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .col       (front_q.source)
  );

  wmf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (front_q.sink),
    .pop  (q_back.source)
  );

  wmf_back u_back (
    .clk (clk),
    .rst (rst),
    .col (q_back.sink),
    .res (res)
  );

endmodule

[rtl/core/wmf_checker.sv]
// Port-level checks of the window median filter, bound to the top level.
module wmf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [wmf_pkg::PIX_W-1:0] median,
  input logic [wmf_pkg::ROW_W-1:0] out_row,
  input logic [wmf_pkg::COL_W-1:0] out_col,
  input logic                      frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(median) && $stable(out_row) && $stable(out_col) && $stable(frame_last))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !out_valid)
    else $error("result present right after reset");

  a_reset_ready: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> in_ready)
    else $error("input not ready right after reset");

endmodule

bind window_median_filter wmf_checker u_wmf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pix.ready),
  .out_valid  (res.valid),
  .out_ready  (res.ready),
  .median     (res.median),
  .out_row    (res.out_row),
  .out_col    (res.out_col),
  .frame_last (res.frame_last)
);

[tb/testbench.sv]
// Self-checking testbench for window_median_filter: streams frames and checks every median.
module testbench;
  import wmf_pkg::*;

  // narrow frames stay within this many columns, and a full strip of it is written first
  localparam int PREFILL_W = 16;

  typedef struct packed {
    pix_t pixel;
    logic frame_start;
  } pix_item_t;

  typedef struct packed {
    pix_t             median;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } filt_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wmf_pix_if pix ();
  wmf_res_if res ();

  window_median_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .res       (res)
  );

  // filter state mirrored by the testbench
  pix_t                line_mem [WIN_H][MAX_WIDTH];
  int unsigned         col_cnt = 0;
  int unsigned         row_cnt = 0;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [CTR_W-1:0]    ccol_reg;
  logic [CTR_W-1:0]    crow_reg;

  pix_item_t    pixel_queue [$];
  filt_result_t awaited_medians [$];
  pix_item_t    cur_pixel;

  int  queued_count;
  int  accepted_count = 0;
  int  checked_count = 0;
  int  err_count = 0;
  int  setting_count;
  int  random_count;
  int  src_gap = 0;
  int  sink_gap = 0;
  bit  idle_on;

  task automatic filter_pixel(input pix_t px, input logic fs);
    int unsigned  w, h, cc, cr, r, c, c0;
    pix_t         v [WIN_N];
    pix_t         t;
    filt_result_t e;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    cc = (ccol_reg > WIN_W - 1) ? WIN_W - 1 : ccol_reg;
    cr = (crow_reg > WIN_H - 1) ? WIN_H - 1 : crow_reg;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    r = row_cnt;
    c = col_cnt;
    if (c < MAX_WIDTH) line_mem[r % WIN_H][c] = px;
    if (c < w && r < h && r >= WIN_H - 1 && c >= WIN_W - 1) begin
      c0 = c - (WIN_W - 1);
      for (int k = 0; k < WIN_H; k++) begin
        for (int l = 0; l < WIN_W; l++) begin
          v[k * WIN_W + l] = line_mem[(r + 1 + k) % WIN_H][c0 + l];
        end
      end
      for (int i = 0; i < WIN_N - 1; i++) begin
        for (int j = 0; j < WIN_N - 1 - i; j++) begin
          if (v[j] > v[j + 1]) begin
            t = v[j];
            v[j] = v[j + 1];
            v[j + 1] = t;
          end
        end
      end
      if (WIN_N % 2 == 1) begin
        e.median = v[WIN_N / 2];
      end else begin
        e.median = PIX_W'((int'(v[MID_LO]) + int'(v[MID_HI])) >> 1);
      end
      e.row  = ROW_W'(r - (WIN_H - 1) + cr);
      e.col  = COL_W'(c0 + cc);
      e.last = (r == h - 1 && c == w - 1);
      awaited_medians.push_back(e);
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg  = val[WIDTH_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg = val[HEIGHT_W-1:0];
      CFG_CENTER_COL:   ccol_reg   = val[CTR_W-1:0];
      CFG_CENTER_ROW:   crow_reg   = val[CTR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int unsigned w, input int unsigned h,
                               input int unsigned cc, input int unsigned cr);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_CENTER_COL, cc);
    write_reg(CFG_CENTER_ROW, cr);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  task automatic push_pixel(input int unsigned px, input bit fs);
    pix_item_t it;
    it.pixel       = px[PIX_W-1:0];
    it.frame_start = fs;
    pixel_queue.push_back(it);
    queued_count++;
  endtask

  function automatic int unsigned gen_pixel(input int mode);
    case (mode)
      1:       return $urandom_range(0, 3) * 85;
      2:       return $urandom_range(0, 1) ? 255 : 0;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic add_frame(input int n, input bit lead_fs, input int mode);
    for (int i = 0; i < n; i++) push_pixel(gen_pixel(mode), lead_fs && i == 0);
  endtask

  task automatic drain();
    while (accepted_count != queued_count || awaited_medians.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("testbench: errors");
    $finish;
  end

  // source side: one pixel transfer per valid/ready, random bursts of idle
  always @(posedge clk) begin
    if (rst) begin
      pix.valid       <= 1'b0;
      pix.pixel       <= '0;
      pix.frame_start <= 1'b0;
    end else if (!pix.valid || pix.ready) begin
      if (pix.valid) begin
        filter_pixel(pix.pixel, pix.frame_start);
        accepted_count++;
      end
      if (src_gap > 0) begin
        src_gap--;
        pix.valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        cur_pixel = pixel_queue.pop_front();
        pix.valid       <= 1'b1;
        pix.pixel       <= cur_pixel.pixel;
        pix.frame_start <= cur_pixel.frame_start;
        if (idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 6);
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // sink side: check each result transfer against the oldest awaited median
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (awaited_medians.size() == 0) begin
          $error("unexpected result: median %0d row %0d col %0d last %0d",
                 res.median, res.out_row, res.out_col, res.frame_last);
          err_count++;
        end else begin
          filt_result_t e;
          e = awaited_medians.pop_front();
          checked_count++;
          if (res.median !== e.median) begin
            $error("median: expected %0d, actual %0d", e.median, res.median);
            err_count++;
          end
          if (res.out_row !== e.row) begin
            $error("out_row: expected %0d, actual %0d", e.row, res.out_row);
            err_count++;
          end
          if (res.out_col !== e.col) begin
            $error("out_col: expected %0d, actual %0d", e.col, res.out_col);
            err_count++;
          end
          if (res.frame_last !== e.last) begin
            $error("frame_last: expected %0d, actual %0d", e.last, res.frame_last);
            err_count++;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 6);
      end
    end
  end

  initial begin
    int unsigned wv, hv, w_eff, h_eff, frame_size;
    int          budget, sent, n, kind, mode;
    bit          lead_fs;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_IMAGE_WIDTH;
    cfg_data        = '0;
    width_reg       = 640;
    height_reg      = 480;
    ccol_reg        = 1;
    crow_reg        = 1;
    queued_count    = 0;
    setting_count   = 0;
    random_count    = 0;
    idle_on         = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // WIN_H rows of the narrow-frame width: every column a narrow window reads gets written
    apply_setting(PREFILL_W, WIN_H, 1, 1);
    add_frame(PREFILL_W * WIN_H, 1'b1, 0);
    drain();

    // smallest window-sized frames: extremes, back-to-back frames, restart mid-frame
    apply_setting(WIN_W, WIN_H, 0, 0);
    for (int i = 0; i < WIN_N; i++) push_pixel((i % 2) ? 255 : 0, i == 0);
    for (int i = 0; i < WIN_N; i++) push_pixel(255 - i * 31, 1'b0);
    push_pixel(17, 1'b0);
    push_pixel(200, 1'b1);
    drain();

    while (random_count < 1530) begin
      if (random_count >= 1300) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0:       wv = 0;
        1:       wv = 1;
        2:       wv = 2;
        3:       wv = 4095;
        4:       wv = MAX_WIDTH;
        default: wv = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       hv = 0;
        1:       hv = 1;
        2:       hv = 2;
        3:       hv = 8191;
        4:       hv = MAX_HEIGHT;
        default: hv = $urandom_range(3, 8);
      endcase
      apply_setting(wv | ($urandom_range(0, 1) << WIDTH_W), hv,
                    $urandom_range(0, 7) | ($urandom_range(0, 3) << CTR_W),
                    $urandom_range(0, 7) | ($urandom_range(0, 3) << CTR_W));
      w_eff = (wv < 1) ? 1 : (wv > MAX_WIDTH) ? MAX_WIDTH : wv;
      h_eff = (hv < 1) ? 1 : (hv > MAX_HEIGHT) ? MAX_HEIGHT : hv;
      frame_size = w_eff * h_eff;
      budget = $urandom_range(40, 160);
      sent = 0;
      // some narrow phases carry on from where the previous geometry left the counters;
      // wide phases restart so their windows never reach unwritten columns
      lead_fs = (w_eff > PREFILL_W) || ($urandom_range(0, 3) != 0);
      while (sent < budget) begin
        kind = $urandom_range(0, 9);
        mode = $urandom_range(0, 5);
        if (mode > 2) mode = 0;
        if (kind < 8) begin
          n = (frame_size > budget - sent) ? budget - sent : frame_size;
          add_frame(n, lead_fs, mode);
        end else if (kind == 8) begin
          n = $urandom_range(1, (frame_size > 40) ? 40 : frame_size);
          add_frame(n, lead_fs, mode);
        end else begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            push_pixel(gen_pixel(mode), (lead_fs && i == 0) || $urandom_range(0, 3) == 0);
          end
        end
        sent += n;
        lead_fs = 1'b1;
      end
      random_count += sent;
      drain();
    end

    while (accepted_count != queued_count) @(posedge clk);
    for (int i = 0; i < 2000 && awaited_medians.size() != 0; i++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (awaited_medians.size() != 0) begin
      $error("%0d medians never arrived", awaited_medians.size());
    end
    $display("%0d pixels streamed over %0d register settings", accepted_count, setting_count);
    $display("%0d medians compared, %0d mismatches", checked_count, err_count);
    if (err_count == 0 && awaited_medians.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/wmf_pkg.sv
rtl/core/wmf_ifs.sv
rtl/core/wmf_front.sv
rtl/core/wmf_queue.sv
rtl/core/wmf_back.sv
rtl/core/window_median_filter.sv
rtl/core/wmf_checker.sv
tb/testbench.sv
